// ===== sv/spcm_pkg.sv =====
package spcm_pkg;

	localparam int DEF_MAX_VERTICES = 64;
	localparam int DEF_MAX_EDGES    = 256;

	// vertex ids are 6 bits wide on every channel, so at most 64 vertices are addressable
	localparam int VTX_NUM    = 64;
	localparam int VTX_W      = 6;
	localparam int NVTX_W     = 7;
	localparam int AMT_W      = 16;
	localparam int ACT_W      = 2;
	localparam int DIST_W     = 30;
	localparam int BEST_W     = 22;
	localparam int CNT_W      = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	localparam logic [DIST_W-1:0] DIST_INF = '1;

	localparam logic [ACT_W-1:0] ACT_WEIGHT  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_EDGE    = 2'd1;
	localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;
	localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_VCOUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SRC    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEST   = 2'd2;

	typedef struct packed {
		logic [NVTX_W-1:0] vertex_count;
		logic [VTX_W-1:0]  source_vertex;
		logic [VTX_W-1:0]  dest_vertex;
	} cfg_t;

	typedef struct packed {
		logic [ACT_W-1:0] action;
		logic [VTX_W-1:0] vertex_a;
		logic [VTX_W-1:0] vertex_b;
		logic [AMT_W-1:0] amount;
	} in_word_t;

	typedef struct packed {
		logic [CNT_W-1:0]  path_count;
		logic [BEST_W-1:0] best_weight;
		logic              edge_overflow;
	} res_t;

endpackage

// ===== sv/spcm_if.sv =====
interface spcm_in_if;
	import spcm_pkg::*;
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic [VTX_W-1:0] vertex_a;
	logic [VTX_W-1:0] vertex_b;
	logic [AMT_W-1:0] amount;
	modport source (output valid, action, vertex_a, vertex_b, amount, input ready);
	modport sink (input valid, action, vertex_a, vertex_b, amount, output ready);
endinterface

interface spcm_out_if;
	import spcm_pkg::*;
	logic              valid;
	logic              ready;
	logic [CNT_W-1:0]  path_count;
	logic [BEST_W-1:0] best_weight;
	logic              edge_overflow;
	modport source (output valid, path_count, best_weight, edge_overflow, input ready);
	modport sink (input valid, path_count, best_weight, edge_overflow, output ready);
endinterface

interface spcm_cfg_if;
	import spcm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/shortest_path_count_max_weight.sv =====
// Shortest-path counter, Bellman-Ford relaxation with max vertex-weight tie break.
//
// Channels: in_ch takes words {action, vertex_a, vertex_b, amount}; out_ch returns
// {path_count, best_weight, edge_overflow}, one word per compute; cfg writes
// vertex_count (0), source_vertex (1), dest_vertex (2), index 3 is ignored.
// Config is taken every cycle and must only be written while the block is idle.
//
// Weight, edge and clear words are accepted one per cycle while idle; no output.
// A compute word runs: a clear pass over the vertex memory (MAX_VERTICES entries,
// capped at 64), a source seed, then n-1 rounds over n vertices, each walking
// the whole edge store (both ends of each edge checked in turn), with a read and
// compare per relaxation, a skip for each edge out of an unreached vertex, and a
// predecessor sum for each tie (counts are summed one memory read per cycle).
// The result is read from the dest vertex after the final round check.
// The vertex state memory's single read port serializes all of these steps.
//
// Reset clears config to vertex_count 1, source 0, dest 0 and empties the edge
// store. Weights are undefined until written. A result waits in the output
// register while the receiver stalls; load words are still taken meanwhile, and
// a following compute holds its result until that register frees up.
module shortest_path_count_max_weight #(
	parameter int MAX_VERTICES = spcm_pkg::DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = spcm_pkg::DEF_MAX_EDGES
) (
	input logic         clk,
	input logic         arst_n,
	spcm_in_if.sink     in_ch,
	spcm_out_if.source  out_ch,
	spcm_cfg_if.sink    cfg
);
	import spcm_pkg::*;

	cfg_t     cfg_q;
	in_word_t in_word;
	res_t     res, out_q;
	logic     out_valid_q, out_free, seq_ready, seq_done;

	// config registers, written whenever the port offers a word
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vertex_count  <= NVTX_W'(1);
			cfg_q.source_vertex <= '0;
			cfg_q.dest_vertex   <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_VCOUNT: cfg_q.vertex_count  <= cfg.data;
				CFG_SRC:    cfg_q.source_vertex <= cfg.data[VTX_W-1:0];
				CFG_DEST:   cfg_q.dest_vertex   <= cfg.data[VTX_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign in_word = '{action: in_ch.action, vertex_a: in_ch.vertex_a,
	                   vertex_b: in_ch.vertex_b, amount: in_ch.amount};
	assign in_ch.ready = seq_ready;

	spcm_seq #(
		.MAX_VERTICES(MAX_VERTICES),
		.MAX_EDGES   (MAX_EDGES)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_valid(in_ch.valid),
		.in_ready(seq_ready),
		.in_word (in_word),
		.out_free(out_free),
		.done    (seq_done),
		.res     (res)
	);

	// output register: frees up in the cycle the receiver takes the word
	assign out_free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_done) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			out_q <= res;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.path_count    = out_q.path_count;
	assign out_ch.best_weight   = out_q.best_weight;
	assign out_ch.edge_overflow = out_q.edge_overflow;

endmodule

// ===== sv/spcm_seq.sv =====
module spcm_seq #(
	parameter int MAX_VERTICES = spcm_pkg::DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = spcm_pkg::DEF_MAX_EDGES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  spcm_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  spcm_pkg::in_word_t in_word,
	input  logic              out_free,
	output logic              done,
	output spcm_pkg::res_t    res
);
	import spcm_pkg::*;

	localparam int NV   = (MAX_VERTICES < VTX_NUM) ? MAX_VERTICES : VTX_NUM;
	localparam int VI_W = $clog2(NV);
	localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EC_W = $clog2(MAX_EDGES + 1);

	typedef struct packed {
		logic [DIST_W-1:0] dval;
		logic [BEST_W-1:0] best;
		logic [CNT_W-1:0]  cnt;
	} vstate_t;

	typedef struct packed {
		logic [VTX_W-1:0] a;
		logic [VTX_W-1:0] b;
		logic [AMT_W-1:0] len;
	} edge_t;

	typedef enum logic [4:0] {
		S_IDLE, S_CLR, S_SRC, S_SRC2, S_ROUND, S_UVTX, S_EDGE, S_EDGE_RD,
		S_CHK, S_NEXT, S_RU, S_RV, S_SUM, S_WB, S_RES, S_RES2, S_OUT
	} state_t;

	// storage
	logic [AMT_W-1:0] wt_mem [NV];
	vstate_t          vs_mem [NV];
	logic [NV-1:0]    pred_mem [NV];
	edge_t            edge_mem [MAX_EDGES];

	logic [AMT_W-1:0] wt_rd_q;
	vstate_t          vs_rd_q;
	logic [NV-1:0]    pred_rd_q;
	edge_t            edge_rd_q;

	logic             wt_we, vs_we, pred_we, edge_we;
	logic [VI_W-1:0]  wt_wa, wt_ra, vs_wa, vs_ra;
	logic [AMT_W-1:0] wt_wd;
	vstate_t          vs_wd;
	logic [NV-1:0]    pred_wd;
	logic [EA_W-1:0]  edge_wa, edge_ra;
	edge_t            edge_wd;

	// control
	state_t            state_q;
	logic [NVTX_W-1:0] r_q, u_q, k_q;
	logic [EC_W-1:0]   e_q, edge_total_q;
	logic              edge_drop_q, side_q, take_s1;
	logic [VTX_W-1:0]  v_q;
	edge_t             eg_q;
	logic [DIST_W-1:0] du_q, dv_q;
	logic [BEST_W-1:0] bu_q, best_q;
	logic [CNT_W-1:0]  cu_q, total_q;
	logic [NV-1:0]     pred_q;
	res_t              res_q;

	logic [NVTX_W-1:0] n_eff;
	logic [VTX_W-1:0]  v_cand;
	logic [DIST_W:0]   nd;
	logic [BEST_W-1:0] cand;
	logic              nd_lt, nd_eq;
	logic [NV-1:0]     u_bit;
	logic [CNT_W:0]    acc;

	assign n_eff  = (cfg.vertex_count > NVTX_W'(NV)) ? NVTX_W'(NV) : cfg.vertex_count;
	assign v_cand = side_q ? eg_q.a : eg_q.b;
	assign nd     = {1'b0, du_q} + (DIST_W + 1)'(eg_q.len);
	assign cand   = bu_q + BEST_W'(wt_rd_q);
	assign nd_lt  = nd < {1'b0, vs_rd_q.dval};
	assign nd_eq  = nd == {1'b0, vs_rd_q.dval};
	assign u_bit  = {{(NV - 1){1'b0}}, 1'b1} << u_q[VI_W-1:0];
	assign acc    = {1'b0, total_q} + {1'b0, vs_rd_q.cnt};

	assign in_ready = (state_q == S_IDLE);
	assign done     = (state_q == S_OUT) && out_free;
	assign res      = res_q;

	always_ff @(posedge clk) begin
		if (wt_we) begin
			wt_mem[wt_wa] <= wt_wd;
		end
		wt_rd_q <= wt_mem[wt_ra];
	end

	always_ff @(posedge clk) begin
		if (vs_we) begin
			vs_mem[vs_wa] <= vs_wd;
		end
		vs_rd_q <= vs_mem[vs_ra];
	end

	always_ff @(posedge clk) begin
		if (pred_we) begin
			pred_mem[vs_wa] <= pred_wd;
		end
		pred_rd_q <= pred_mem[v_q[VI_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edge_wa] <= edge_wd;
		end
		edge_rd_q <= edge_mem[edge_ra];
	end

	always_comb begin
		wt_we   = 1'b0;
		wt_wa   = in_word.vertex_a[VI_W-1:0];
		wt_wd   = in_word.amount;
		wt_ra   = v_q[VI_W-1:0];
		edge_we = 1'b0;
		edge_wa = edge_total_q[EA_W-1:0];
		edge_wd = '{a: in_word.vertex_a, b: in_word.vertex_b, len: in_word.amount};
		edge_ra = e_q[EA_W-1:0];
		vs_we   = 1'b0;
		pred_we = 1'b0;
		vs_wa   = v_q[VI_W-1:0];
		vs_wd   = '{dval: dv_q, best: best_q, cnt: total_q};
		pred_wd = pred_q;
		vs_ra   = u_q[VI_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_word.action == ACT_WEIGHT &&
				    NVTX_W'(in_word.vertex_a) < NVTX_W'(NV)) begin
					wt_we = 1'b1;
				end
				if (in_valid && in_word.action == ACT_EDGE &&
				    edge_total_q < EC_W'(MAX_EDGES)) begin
					edge_we = 1'b1;
				end
			end
			S_CLR: begin
				vs_we   = 1'b1;
				pred_we = 1'b1;
				vs_wa   = k_q[VI_W-1:0];
				vs_wd   = '{dval: DIST_INF, best: '0, cnt: '0};
				pred_wd = '0;
			end
			S_SRC: begin
				wt_ra = cfg.source_vertex[VI_W-1:0];
			end
			S_SRC2: begin
				vs_wa = cfg.source_vertex[VI_W-1:0];
				vs_wd = '{dval: '0, best: BEST_W'(wt_rd_q), cnt: CNT_W'(1)};
				vs_we = NVTX_W'(cfg.source_vertex) < n_eff;
			end
			S_RU: begin
				vs_ra = v_q[VI_W-1:0];
			end
			S_RV: begin
				if (nd_lt) begin
					vs_we   = 1'b1;
					pred_we = 1'b1;
					vs_wd   = '{dval: nd[DIST_W-1:0], best: cand, cnt: cu_q};
					pred_wd = u_bit;
				end
			end
			S_SUM: begin
				vs_ra = k_q[VI_W-1:0];
			end
			S_WB: begin
				vs_we   = 1'b1;
				pred_we = 1'b1;
			end
			S_RES: begin
				vs_ra = cfg.dest_vertex[VI_W-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			edge_total_q <= '0;
			edge_drop_q  <= 1'b0;
			take_s1      <= 1'b0;
			side_q       <= 1'b0;
			r_q          <= '0;
			u_q          <= '0;
			k_q          <= '0;
			e_q          <= '0;
		end else begin
			// count read for k lands next cycle together with take_s1
			take_s1 <= (state_q == S_SUM) && (k_q < n_eff) && pred_q[k_q[VI_W-1:0]];
			if (take_s1) begin
				total_q <= acc[CNT_W] ? '1 : acc[CNT_W-1:0];
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						unique case (in_word.action)
							ACT_EDGE: begin
								if (edge_total_q < EC_W'(MAX_EDGES)) begin
									edge_total_q <= edge_total_q + 1'b1;
								end else begin
									edge_drop_q <= 1'b1;
								end
							end
							ACT_CLEAR: begin
								edge_total_q <= '0;
								edge_drop_q  <= 1'b0;
							end
							ACT_COMPUTE: begin
								k_q     <= '0;
								state_q <= S_CLR;
							end
							default: begin
							end
						endcase
					end
				end
				S_CLR: begin
					k_q <= k_q + 1'b1;
					if (k_q == NVTX_W'(NV - 1)) begin
						state_q <= S_SRC;
					end
				end
				S_SRC: state_q <= S_SRC2;
				S_SRC2: begin
					r_q     <= NVTX_W'(1);
					state_q <= S_ROUND;
				end
				S_ROUND: begin
					u_q     <= '0;
					state_q <= (r_q < n_eff) ? S_UVTX : S_RES;
				end
				S_UVTX: begin
					e_q <= '0;
					if (u_q < n_eff) begin
						state_q <= S_EDGE;
					end else begin
						r_q     <= r_q + 1'b1;
						state_q <= S_ROUND;
					end
				end
				S_EDGE: begin
					if (e_q < edge_total_q) begin
						state_q <= S_EDGE_RD;
					end else begin
						u_q     <= u_q + 1'b1;
						state_q <= S_UVTX;
					end
				end
				S_EDGE_RD: begin
					eg_q    <= edge_rd_q;
					side_q  <= 1'b0;
					state_q <= S_CHK;
				end
				S_CHK: begin
					// side 0 relaxes a->b, side 1 relaxes b->a
					if ((side_q ? eg_q.b : eg_q.a) == u_q[VTX_W-1:0]) begin
						v_q     <= v_cand;
						state_q <= (NVTX_W'(v_cand) < n_eff) ? S_RU : S_NEXT;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_NEXT: begin
					if (!side_q) begin
						side_q  <= 1'b1;
						state_q <= S_CHK;
					end else begin
						e_q     <= e_q + 1'b1;
						state_q <= S_EDGE;
					end
				end
				S_RU: begin
					du_q    <= vs_rd_q.dval;
					bu_q    <= vs_rd_q.best;
					cu_q    <= vs_rd_q.cnt;
					state_q <= (vs_rd_q.dval == DIST_INF) ? S_NEXT : S_RV;
				end
				S_RV: begin
					dv_q <= vs_rd_q.dval;
					if (!nd_lt && nd_eq) begin
						best_q  <= (cand > vs_rd_q.best) ? cand : vs_rd_q.best;
						pred_q  <= pred_rd_q | u_bit;
						total_q <= '0;
						k_q     <= '0;
						state_q <= S_SUM;
					end else begin
						state_q <= S_NEXT;
					end
				end
				S_SUM: begin
					if (k_q < n_eff) begin
						k_q <= k_q + 1'b1;
					end else begin
						state_q <= S_WB;
					end
				end
				S_WB: state_q <= S_NEXT;
				S_RES: state_q <= S_RES2;
				S_RES2: begin
					if (NVTX_W'(cfg.dest_vertex) < n_eff && vs_rd_q.dval != DIST_INF) begin
						res_q.path_count  <= vs_rd_q.cnt;
						res_q.best_weight <= vs_rd_q.best;
					end else begin
						res_q.path_count  <= '0;
						res_q.best_weight <= '0;
					end
					res_q.edge_overflow <= edge_drop_q;
					state_q             <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SUM) |-> (k_q <= n_eff))
		else $error("predecessor sum index ran past vertex count");

	a_edge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		edge_total_q <= EC_W'(MAX_EDGES))
		else $error("edge count beyond store depth");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		edge_drop_q |-> (edge_total_q == EC_W'(MAX_EDGES)))
		else $error("edge drop flagged with room left");

	a_relax_reached: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RV) |-> (du_q != DIST_INF))
		else $error("relaxing out of an unreached vertex");

endmodule

// ===== tb/spcm_checker.sv =====
module spcm_checker (
	input  logic clk,
	input  logic arst_n,
	spcm_in_if   in_ch,
	spcm_out_if  out_ch,
	spcm_cfg_if  cfg,
	output int   fail_count,
	output int   outstanding,
	output int   checked
);
	import spcm_pkg::*;

	typedef struct {
		int unsigned a;
		int unsigned b;
		int unsigned len;
	} link_t;

	localparam int unsigned INF_DIST  = 32'(DIST_INF);
	localparam int unsigned BEST_MASK = (1 << BEST_W) - 1;

	// predictor copy of config and load state
	int unsigned n_cfg, src_cfg, dst_cfg;
	int unsigned vtx_wt [VTX_NUM];
	link_t       links[$];
	bit          links_dropped;

	// per-search scratch
	int unsigned n_act;
	int unsigned dlen [VTX_NUM];
	int unsigned best [VTX_NUM];
	int unsigned cnt  [VTX_NUM];
	logic [63:0] pred [VTX_NUM];

	res_t path_q[$];

	function automatic int unsigned sat_sum(int unsigned x, int unsigned y);
		logic [32:0] s;
		s = {1'b0, x} + {1'b0, y};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	task automatic relax_link(int unsigned u, int unsigned v, int unsigned len);
		int unsigned nd, cand, tot;
		if (u >= n_act || v >= n_act) return;
		if (dlen[u] == INF_DIST) return;
		nd   = dlen[u] + len;
		cand = (best[u] + vtx_wt[v]) & BEST_MASK;
		if (nd < dlen[v]) begin
			dlen[v] = nd;
			best[v] = cand;
			cnt[v]  = cnt[u];
			pred[v] = 64'd1 << u;
		end
		if (nd == dlen[v]) begin
			if (cand > best[v]) best[v] = cand;
			pred[v] |= 64'd1 << u;
			tot = 0;
			for (int k = 0; k < n_act; k++)
				if (pred[v][k]) tot = sat_sum(tot, cnt[k]);
			cnt[v] = tot;
		end
	endtask

	task automatic run_search(output res_t r);
		n_act = (n_cfg > VTX_NUM) ? VTX_NUM : n_cfg;
		for (int v = 0; v < VTX_NUM; v++) begin
			dlen[v] = INF_DIST;
			best[v] = 0;
			cnt[v]  = 0;
			pred[v] = '0;
		end
		if (src_cfg < n_act) begin
			dlen[src_cfg] = 0;
			best[src_cfg] = vtx_wt[src_cfg] & BEST_MASK;
			cnt[src_cfg]  = 1;
		end
		for (int rnd = 1; rnd < n_act; rnd++)
			for (int u = 0; u < n_act; u++)
				foreach (links[e]) begin
					if (links[e].a == u) relax_link(u, links[e].b, links[e].len);
					if (links[e].b == u) relax_link(u, links[e].a, links[e].len);
				end
		if (dst_cfg < n_act && dlen[dst_cfg] != INF_DIST) begin
			r.path_count  = cnt[dst_cfg];
			r.best_weight = best[dst_cfg][BEST_W-1:0];
		end else begin
			r.path_count  = '0;
			r.best_weight = '0;
		end
		r.edge_overflow = links_dropped;
	endtask

	initial begin
		foreach (vtx_wt[i]) vtx_wt[i] = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		res_t  want, got;
		link_t lk;
		if (!arst_n) begin
			n_cfg         = 1;
			src_cfg       = 0;
			dst_cfg       = 0;
			links.delete();
			links_dropped = 0;
			path_q.delete();
			fail_count    <= 0;
			outstanding   <= 0;
			checked       <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_VCOUNT: n_cfg   = 32'(cfg.data);
					CFG_SRC:    src_cfg = 32'(cfg.data[VTX_W-1:0]);
					CFG_DEST:   dst_cfg = 32'(cfg.data[VTX_W-1:0]);
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready) begin
				case (in_ch.action)
					ACT_WEIGHT: vtx_wt[in_ch.vertex_a] = 32'(in_ch.amount);
					ACT_EDGE: begin
						if (links.size() < DEF_MAX_EDGES) begin
							lk.a   = 32'(in_ch.vertex_a);
							lk.b   = 32'(in_ch.vertex_b);
							lk.len = 32'(in_ch.amount);
							links  = {links, lk};
						end else begin
							links_dropped = 1;
						end
					end
					ACT_CLEAR: begin
						links.delete();
						links_dropped = 0;
					end
					default: begin
						run_search(want);
						path_q = {path_q, want};
					end
				endcase
			end
			if (out_ch.valid && out_ch.ready) begin
				got.path_count    = out_ch.path_count;
				got.best_weight   = out_ch.best_weight;
				got.edge_overflow = out_ch.edge_overflow;
				if (path_q.size() == 0) begin
					if (fail_count < 10)
						$display("ERROR: unexpected result count=%0d weight=%0d ovf=%0b",
							got.path_count, got.best_weight, got.edge_overflow);
					fail_count <= fail_count + 1;
				end else begin
					want = path_q.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("ERROR: result %0d exp count=%0d weight=%0d ovf=%0b, got count=%0d weight=%0d ovf=%0b",
								checked, want.path_count, want.best_weight, want.edge_overflow,
								got.path_count, got.best_weight, got.edge_overflow);
						fail_count <= fail_count + 1;
					end
					checked <= checked + 1;
				end
			end
			outstanding <= path_q.size();
		end
	end

endmodule

// ===== tb/shortest_path_count_max_weight_tb.sv =====
module shortest_path_count_max_weight_tb;
	import spcm_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int STALL_LIMIT = 400000; // watchdog limit; longest search here has 64 vertices, few edges
	localparam int SETTLE      = 8;      // load words are written at the edge that accepts them

	logic clk;
	logic arst_n;

	spcm_in_if  in_ch ();
	spcm_out_if out_ch ();
	spcm_cfg_if cfg_ch ();

	int fail_count, outstanding, checked;
	int tx_idle_pct, rx_idle_pct;
	bit rx_hold;
	int words_sent, searches_sent;
	int links_loaded;  // edges in store, used to keep searches cheap
	int unsigned nv;   // vertex count currently programmed
	int stall_cyc;

	shortest_path_count_max_weight u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	spcm_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.cfg         (cfg_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding),
		.checked     (checked)
	);

	always #HALF_PERIOD clk = ~clk;

	// receiver: random stalls, plus a forced hold-off for the backpressure test
	always @(negedge clk) begin
		out_ch.ready <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
	end

	// watchdog: cycles with no handshake on any channel
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
		    (cfg_ch.valid && cfg_ch.ready))
			stall_cyc <= 0;
		else
			stall_cyc <= stall_cyc + 1;
		if (stall_cyc >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic send_word(logic [ACT_W-1:0] act, int unsigned va,
	                         int unsigned vb, int unsigned amt);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid    = 1'b1;
		in_ch.action   = act;
		in_ch.vertex_a = VTX_W'(va);
		in_ch.vertex_b = VTX_W'(vb);
		in_ch.amount   = AMT_W'(amt);
		do @(posedge clk); while (!in_ch.ready);
		@(negedge clk);
		in_ch.valid = 1'b0;
		words_sent++;
		if (act == ACT_COMPUTE) searches_sent++;
		if (act == ACT_EDGE) links_loaded++;
		if (act == ACT_CLEAR) links_loaded = 0;
	endtask

	// config only moves while the block is idle
	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.index = idx;
		cfg_ch.data  = CFG_DATA_W'(val);
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
		if (idx == CFG_VCOUNT) nv = val & 32'h7F;
	endtask

	task automatic set_graph(int unsigned n, int unsigned s, int unsigned d);
		set_reg(CFG_VCOUNT, n);
		set_reg(CFG_SRC, s);
		set_reg(CFG_DEST, d);
	endtask

	task automatic random_phase(int count);
		int unsigned r, top_v;
		int unsigned len;
		for (int i = 0; i < count; i++) begin
			if (i % 90 == 0) begin
				// mostly small graphs; now and then an empty one
				r = ($urandom_range(19) == 0) ? 0 : $urandom_range(2, 9);
				set_graph(r, $urandom_range(0, r), $urandom_range(0, r));
			end
			top_v = (nv > 1) ? nv : 2;
			r = $urandom_range(99);
			if (r < 8)
				send_word(ACT_COMPUTE, $urandom, $urandom, $urandom);
			else if (r < 12)
				send_word(ACT_CLEAR, $urandom, $urandom, $urandom);
			else if (r < 55 && links_loaded < 14) begin
				// short lengths make ties common
				case ($urandom_range(9))
					0:       len = 32'hFFFF;
					1, 2:    len = $urandom_range(0, 32'hFFFF);
					default: len = $urandom_range(0, 3);
				endcase
				if ($urandom_range(9) == 0)
					send_word(ACT_EDGE, $urandom, $urandom, len);
				else
					send_word(ACT_EDGE, $urandom_range(0, top_v),
						$urandom_range(0, top_v), len);
			end else
				send_word(ACT_WEIGHT, $urandom, $urandom,
					($urandom_range(3) == 0) ? $urandom_range(0, 7) : $urandom);
		end
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.action  = ACT_WEIGHT;
		in_ch.vertex_a = '0;
		in_ch.vertex_b = '0;
		in_ch.amount  = '0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = CFG_VCOUNT;
		cfg_ch.data   = '0;
		out_ch.ready  = 1'b0;
		rx_hold       = 0;
		tx_idle_pct   = 6;
		rx_idle_pct   = 81;
		nv            = 1;
		stall_cyc     = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// every weight gets written before any search can read it
		for (int v = 0; v < VTX_NUM; v++)
			send_word(ACT_WEIGHT, v, 0, (v == 0) ? 32'hFFFF : (v == 1) ? 0 : $urandom);

		// reset config: lone vertex reaches itself
		send_word(ACT_COMPUTE, 0, 0, 0);

		// diamond with a tie into 3, a self loop, an edge to an unused vertex
		set_graph(4, 0, 3);
		send_word(ACT_EDGE, 0, 1, 2);
		send_word(ACT_EDGE, 0, 2, 1);
		send_word(ACT_EDGE, 1, 3, 1);
		send_word(ACT_EDGE, 2, 3, 2);
		send_word(ACT_EDGE, 3, 3, 0);
		send_word(ACT_EDGE, 2, 10, 5);
		send_word(ACT_EDGE, 63, 0, 32'hFFFF);
		send_word(ACT_COMPUTE, 0, 0, 0);
		set_reg(CFG_DEST, 63);            // dest beyond vertex count
		send_word(ACT_COMPUTE, 0, 0, 0);
		set_reg(CFG_DEST, 3);
		set_reg(CFG_SRC, 40);             // source beyond vertex count
		send_word(ACT_COMPUTE, 0, 0, 0);
		set_graph(6, 0, 5);               // dest unreachable
		send_word(ACT_COMPUTE, 0, 0, 0);
		set_reg(CFG_VCOUNT, 0);           // no vertices at all
		send_word(ACT_COMPUTE, 0, 0, 0);

		// oversized count caps at 64; keep the edge list tiny, these are slow
		send_word(ACT_CLEAR, 0, 0, 0);
		send_word(ACT_EDGE, 63, 0, 32'hFFFF);
		send_word(ACT_EDGE, 0, 62, 1);
		set_graph(127, 63, 62);
		send_word(ACT_COMPUTE, 0, 0, 0);
		set_graph(64, 0, 63);
		send_word(ACT_COMPUTE, 0, 0, 0);

		// fill the edge store past capacity, then clear the overflow flag
		send_word(ACT_CLEAR, 0, 0, 0);
		set_graph(2, 0, 1);
		for (int e = 0; e <= DEF_MAX_EDGES; e++)
			send_word(ACT_EDGE, $urandom, $urandom, $urandom);
		send_word(ACT_COMPUTE, 0, 0, 0);
		send_word(ACT_CLEAR, 0, 0, 0);
		send_word(ACT_EDGE, 1, 0, 7);
		send_word(ACT_COMPUTE, 0, 0, 0);

		// phase 1: slow receiver
		random_phase(335);
		// phase 2: slow sender
		while (outstanding != 0) @(negedge clk);
		tx_idle_pct = 81;
		rx_idle_pct = 6;
		random_phase(335);
		// phase 3: full rate, opening with a long receiver hold-off
		while (outstanding != 0) @(negedge clk);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_graph(3, 0, 2);
		fork
			begin
				rx_hold = 1;
				repeat (400) @(negedge clk);
				rx_hold = 0;
			end
		join_none
		repeat (4) send_word(ACT_COMPUTE, 0, 0, 0);
		random_phase(335);

		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE * 4) @(negedge clk);
		$display("Run: %0d words sent incl. %0d searches, %0d results checked, %0d mismatches",
			words_sent, searches_sent, checked, fail_count);
		$display("Covered ties, self loops, unused source/dest, 0/64/127 vertices, full edge store");
		if (fail_count == 0 && outstanding == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
